>>> rtl/core/two_stacks_one_memory_unit_defines.svh
// Assertion macros shared by the stack unit modules.
`ifndef TWO_STACKS_ONE_MEMORY_UNIT_DEFINES_SVH
`define TWO_STACKS_ONE_MEMORY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSOM_ASSERT_IF(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSOM_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> rtl/core/tsom_pkg.sv
`default_nettype none

package tsom_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    CmdPushOne = 3'd0,
    CmdPopOne  = 3'd1,
    CmdPeekOne = 3'd2,
    CmdPushTwo = 3'd3,
    CmdPopTwo  = 3'd4,
    CmdPeekTwo = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    StsOk        = 2'd0,
    StsOverflow  = 2'd1,
    StsUnderflow = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StAccess = 2'd1,
    StFinish = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [DataW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
    logic [CountW-1:0]       count_one;
    logic [CountW-1:0]       count_two;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic access;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/tsom_ram.sv
`default_nettype none

module tsom_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/tsom_ctrl.sv
`default_nettype none
`include "two_stacks_one_memory_unit_defines.svh"

module tsom_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output tsom_pkg::dp_cmd_t      cmd_o,
  input  wire tsom_pkg::dp_sts_t sts_i
);

  import tsom_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StAccess;
        end
      end
      StAccess: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StAccess: begin
        cmd_o.access = 1'b1;
      end
      StFinish: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `TSOM_ASSERT_NEXT(a_accept_access, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == StAccess)
  `TSOM_ASSERT_NEXT(a_access_finish, clk_i, rst_ni, state_q == StAccess, state_q == StFinish)
  `TSOM_ASSERT_IF(a_load_room, clk_i, rst_ni, cmd_o.load_out, sts_i.out_free)

endmodule

`default_nettype wire

>>> rtl/core/tsom_dp.sv
`default_nettype none
`include "two_stacks_one_memory_unit_defines.svh"

module tsom_dp #(
  parameter int unsigned Capacity = tsom_pkg::DefaultCapacity
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tsom_pkg::in_t     in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tsom_pkg::out_t         out_res_o,
  input  wire tsom_pkg::dp_cmd_t cmd_i,
  output tsom_pkg::dp_sts_t      sts_o
);

  import tsom_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);
  localparam logic [CntW:0] CapSum = (CntW + 1)'(Capacity);

  logic [2:0]       cmd_q;
  logic [DataW-1:0] val_q;
  logic [CntW-1:0]  depth_one_q, depth_one_d;
  logic [CntW-1:0]  depth_two_q, depth_two_d;
  status_e          status_q, status_d;
  logic             rd_ok_q, rd_ok_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q;

  logic [CntW:0]    depth_sum;
  logic             full;
  logic             mem_we;
  logic             mem_re;
  logic [CntW-1:0]  addr_cnt;
  logic [DataW-1:0] mem_rdata;

  assign depth_sum = {1'b0, depth_one_q} + {1'b0, depth_two_q};
  assign full = depth_sum >= CapSum;

  always_comb begin
    depth_one_d = depth_one_q;
    depth_two_d = depth_two_q;
    status_d    = StsOk;
    rd_ok_d     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    addr_cnt    = '0;
    if (cmd_i.access) begin
      case (cmd_q)
        CmdPushOne: begin
          if (full) begin
            status_d = StsOverflow;
          end else begin
            mem_we      = 1'b1;
            addr_cnt    = depth_one_q;
            depth_one_d = depth_one_q + CntW'(1);
          end
        end
        CmdPushTwo: begin
          if (full) begin
            status_d = StsOverflow;
          end else begin
            mem_we      = 1'b1;
            addr_cnt    = CapCnt - CntW'(1) - depth_two_q;
            depth_two_d = depth_two_q + CntW'(1);
          end
        end
        CmdPopOne, CmdPeekOne: begin
          if (depth_one_q == '0) begin
            status_d = StsUnderflow;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
            addr_cnt = depth_one_q - CntW'(1);
            if (cmd_q == CmdPopOne) begin
              depth_one_d = depth_one_q - CntW'(1);
            end
          end
        end
        CmdPopTwo, CmdPeekTwo: begin
          if (depth_two_q == '0) begin
            status_d = StsUnderflow;
          end else begin
            mem_re   = 1'b1;
            rd_ok_d  = 1'b1;
            addr_cnt = CapCnt - depth_two_q;
            if (cmd_q == CmdPopTwo) begin
              depth_two_d = depth_two_q - CntW'(1);
            end
          end
        end
        default: begin
          status_d = StsOk;
        end
      endcase
    end
  end

  tsom_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (addr_cnt[AddrW-1:0]),
    .wdata_i(val_q),
    .rdata_o(mem_rdata)
  );

  assign out_valid_d = cmd_i.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_one_q <= '0;
      depth_two_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_one_q <= depth_one_d;
      depth_two_q <= depth_two_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_req_i.command;
      val_q <= in_req_i.push_value;
    end
    if (cmd_i.access) begin
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
    if (cmd_i.load_out) begin
      out_q.read_value <= rd_ok_q ? $signed(mem_rdata) : '0;
      out_q.status     <= status_q;
      out_q.count_one  <= CountW'(depth_one_q);
      out_q.count_two  <= CountW'(depth_two_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_res_o      = out_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  `TSOM_ASSERT_IF(a_depth_bound, clk_i, rst_ni, 1'b1, depth_sum <= CapSum)
  `TSOM_ASSERT_NEXT(a_depth_hold, clk_i, rst_ni, !cmd_i.access, $stable(depth_one_q) && $stable(depth_two_q))
  `TSOM_ASSERT_IF(a_write_room, clk_i, rst_ni, mem_we, !full)

endmodule

`default_nettype wire

>>> rtl/core/two_stacks_one_memory_unit.sv
// Two LIFO stacks in one shared memory of Capacity words. Stack one grows up
// from word zero and stack two grows down from the last word.
// The request channel (in_valid_i, in_ready_o, in_req_i) carries a command
// and a value to push. The result channel (out_valid_o, out_ready_i,
// out_res_o) returns one result per request: the word popped or peeked, a
// status, and both stack sizes after the command.
// A request passes through capture, one access of the single-port memory
// with the size update, and the registered read into the output register.
// A new request is taken only after the previous one has loaded its result
// into the output register.
// The output register holds a result while the receiver stalls, and the next
// request is still accepted and worked on; it waits to load its result until
// the previous one has been taken.
// Reset clears both stack sizes and the output valid. Memory contents are
// not cleared, since a stack reads only words that it has pushed.
`default_nettype none

module two_stacks_one_memory_unit #(
  parameter int unsigned Capacity = tsom_pkg::DefaultCapacity
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tsom_pkg::in_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tsom_pkg::out_t      out_res_o
);

  import tsom_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tsom_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (dp_cmd),
    .sts_i     (dp_sts)
  );

  tsom_dp #(
    .Capacity(Capacity)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts)
  );

endmodule

`default_nettype wire
